// ===== rtl/tra_pkg.sv =====
// Shared widths, constants and sideband types of the trackball rotation axis block.
package tra_pkg;

    localparam int COORD_W     = 13;
    localparam int DIAM_W      = 13;
    localparam int AXIS_W      = 18;
    localparam int LANES       = 4;
    localparam int POINTS      = 2;
    localparam int FRAC_W      = 16;
    localparam int SCALE_SHIFT = 17;
    localparam int SCALE_NUM_W = 31;
    localparam int MAG_W       = 30;
    localparam int SQ_W        = 60;
    localparam int ROOT_W      = 30;
    localparam int NORM_NUM_W  = 46;
    localparam int NORM_Q_W    = 18;
    localparam int UNIT_W      = 17;
    localparam int PROD_W      = 36;
    localparam int DIFF_W      = 37;

    localparam logic [DIAM_W-1:0] DIAM_RESET = 13'd512;
    localparam logic [SQ_W-1:0]   ONE_Q32    = 60'h0_0000_0001_0000_0000;
    localparam logic [AXIS_W-1:0] ONE_Q16    = 18'd65536;
    localparam logic [DIFF_W-1:0] HALF_Q16   = 37'd32768;

    typedef logic signed [AXIS_W-1:0] axis_t;

    localparam axis_t AXIS_MAX = 18'sd65536;
    localparam axis_t AXIS_MIN = -18'sd65536;

    typedef struct packed {
        logic [LANES-1:0]             neg;
        logic [LANES-1:0][MAG_W-1:0]  mag;
        logic [POINTS-1:0]            on_ball;
    } sqrt_side_t;

    typedef struct packed {
        logic [LANES-1:0]              neg;
        logic [POINTS-1:0]             on_ball;
        logic [LANES-1:0][UNIT_W-1:0]  mag_in;
        logic [POINTS-1:0][UNIT_W-1:0] z;
    } norm_side_t;

endpackage

// ===== rtl/tra_udiv.sv =====
// Pipelined restoring divider, one quotient bit per stage, several lanes in parallel.
module tra_udiv #(
    parameter int LANES  = 1,
    parameter int NUM_W  = 8,
    parameter int DEN_W  = 8,
    parameter int Q_W    = 8,
    parameter int SIDE_W = 1
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [LANES-1:0][NUM_W-1:0]   num,
    input  logic [LANES-1:0][DEN_W-1:0]   den,
    input  logic [SIDE_W-1:0]             side,
    input  logic                          hold_in,
    output logic                          hold_out,
    output logic                          out_valid,
    output logic [LANES-1:0][Q_W-1:0]     quo,
    output logic [SIDE_W-1:0]             out_side
);

    localparam int ACC_W = DEN_W + Q_W;

    function automatic logic [ACC_W-1:0] div_step(
        input logic [ACC_W-1:0] acc,
        input logic [DEN_W-1:0] dv
    );
        logic [ACC_W:0]   t;
        logic [DEN_W:0]   top;
        logic [DEN_W:0]   diff;
        logic             ge;
        t    = {acc, 1'b0};
        top  = t[ACC_W -: DEN_W + 1];
        ge   = (top >= {1'b0, dv});
        diff = top - {1'b0, dv};
        if (ge)
        begin
            return {diff[DEN_W-1:0], t[Q_W-1:1], 1'b1};
        end
        return {top[DEN_W-1:0], t[Q_W-1:1], 1'b0};
    endfunction

    logic [Q_W-1:0]                  valid_reg;
    logic [Q_W-1:0]                  valid_src;
    logic [Q_W-1:0]                  hold;
    logic [LANES-1:0][ACC_W-1:0]     acc_reg  [Q_W];
    logic [LANES-1:0][ACC_W-1:0]     acc_src  [Q_W];
    logic [LANES-1:0][DEN_W-1:0]     den_reg  [Q_W];
    logic [LANES-1:0][DEN_W-1:0]     den_src  [Q_W];
    logic [SIDE_W-1:0]               side_reg [Q_W];
    logic [SIDE_W-1:0]               side_src [Q_W];

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        if (k == 0)
        begin : g_first
            assign valid_src[k] = in_valid;
            assign den_src[k]   = den;
            assign side_src[k]  = side;
            for (genvar l = 0; l < LANES; l++)
            begin : g_lane
                assign acc_src[k][l] = ACC_W'(num[l]);
            end
        end
        else
        begin : g_next
            assign valid_src[k] = valid_reg[k-1];
            assign den_src[k]   = den_reg[k-1];
            assign side_src[k]  = side_reg[k-1];
            assign acc_src[k]   = acc_reg[k-1];
        end

        if (k == Q_W - 1)
        begin : g_hold_last
            assign hold[k] = valid_reg[k] && hold_in;
        end
        else
        begin : g_hold_mid
            assign hold[k] = valid_reg[k] && hold[k+1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (!hold[k])
            begin
                valid_reg[k] <= valid_src[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (!hold[k])
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    acc_reg[k][l] <= div_step(acc_src[k][l], den_src[k][l]);
                end
                den_reg[k]  <= den_src[k];
                side_reg[k] <= side_src[k];
            end
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_out
        assign quo[l] = acc_reg[Q_W-1][l][Q_W-1:0];
    end

    assign hold_out  = hold[0];
    assign out_valid = valid_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

// ===== rtl/tra_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, several lanes in parallel.
module tra_sqrt #(
    parameter int LANES  = 1,
    parameter int V_W    = 8,
    parameter int SIDE_W = 1
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [LANES-1:0][V_W-1:0]     val,
    input  logic [SIDE_W-1:0]             side,
    input  logic                          hold_in,
    output logic                          hold_out,
    output logic                          out_valid,
    output logic [LANES-1:0][V_W/2-1:0]   root,
    output logic [SIDE_W-1:0]             out_side
);

    localparam int R_W  = V_W / 2;
    localparam int ST_W = R_W + 2 + V_W + R_W;

    function automatic logic [ST_W-1:0] sq_step(input logic [ST_W-1:0] st);
        logic [R_W+1:0] rem;
        logic [V_W-1:0] vb;
        logic [R_W-1:0] rt;
        logic [R_W+3:0] sh;
        logic [R_W+3:0] trial;
        logic [R_W+3:0] diff;
        logic           ge;
        rem   = st[ST_W-1 -: R_W + 2];
        vb    = st[V_W+R_W-1 -: V_W];
        rt    = st[R_W-1:0];
        sh    = {rem, vb[V_W-1 -: 2]};
        trial = {2'b00, rt, 2'b01};
        ge    = (sh >= trial);
        diff  = sh - trial;
        if (ge)
        begin
            return {diff[R_W+1:0], vb[V_W-3:0], 2'b00, rt[R_W-2:0], 1'b1};
        end
        return {sh[R_W+1:0], vb[V_W-3:0], 2'b00, rt[R_W-2:0], 1'b0};
    endfunction

    logic [R_W-1:0]              valid_reg;
    logic [R_W-1:0]              valid_src;
    logic [R_W-1:0]              hold;
    logic [LANES-1:0][ST_W-1:0]  st_reg   [R_W];
    logic [LANES-1:0][ST_W-1:0]  st_src   [R_W];
    logic [SIDE_W-1:0]           side_reg [R_W];
    logic [SIDE_W-1:0]           side_src [R_W];

    for (genvar k = 0; k < R_W; k++)
    begin : g_stage
        if (k == 0)
        begin : g_first
            assign valid_src[k] = in_valid;
            assign side_src[k]  = side;
            for (genvar l = 0; l < LANES; l++)
            begin : g_lane
                assign st_src[k][l] = {{(R_W + 2){1'b0}}, val[l], {R_W{1'b0}}};
            end
        end
        else
        begin : g_next
            assign valid_src[k] = valid_reg[k-1];
            assign side_src[k]  = side_reg[k-1];
            assign st_src[k]    = st_reg[k-1];
        end

        if (k == R_W - 1)
        begin : g_hold_last
            assign hold[k] = valid_reg[k] && hold_in;
        end
        else
        begin : g_hold_mid
            assign hold[k] = valid_reg[k] && hold[k+1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (!hold[k])
            begin
                valid_reg[k] <= valid_src[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (!hold[k])
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    st_reg[k][l] <= sq_step(st_src[k][l]);
                end
                side_reg[k] <= side_src[k];
            end
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_out
        assign root[l] = st_reg[R_W-1][l][R_W-1:0];
    end

    assign hold_out  = hold[0];
    assign out_valid = valid_reg[R_W-1];
    assign out_side  = side_reg[R_W-1];

endmodule

// ===== rtl/trackball_rotation_axis.sv =====
// Virtual trackball: maps an old and a new pointer position onto the ball and returns
// their cross product as the rotation axis. The block takes one item per clock cycle while
// the input is not stalled; the pipeline is made of the 31-stage scaling divider, the
// 30-stage square root and the 18-stage rim normalization divider, plus nine stages of
// multiply, add and rounding. A stall on the output fills the bubbles of the pipeline
// first and only then stalls the input. The ball diameter is written through the
// configuration port; the user must write it only while no item is in flight, which
// the block itself does not enforce. A diameter of zero acts as one.
module trackball_rotation_axis
    import tra_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [DIAM_W-1:0]          cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [COORD_W-1:0]  new_x,
    input  logic signed [COORD_W-1:0]  new_y,
    input  logic signed [COORD_W-1:0]  old_x,
    input  logic signed [COORD_W-1:0]  old_y,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [AXIS_W-1:0]   axis_x,
    output logic signed [AXIS_W-1:0]   axis_y,
    output logic signed [AXIS_W-1:0]   axis_z
);

    logic [DIAM_W-1:0] diameter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diameter_reg <= DIAM_RESET;
        end
        else if (cfg_wr_en)
        begin
            diameter_reg <= cfg_wr_data;
        end
    end

    // Hold chain, from the output back to the input.
    logic hold_a, hold_scale, hold_m, hold_s, hold_v, hold_sqrt, hold_n, hold_norm;
    logic hold_f, hold_p, hold_d, hold_o;

    // Stage A: magnitude, sign and rounding bias for the scaling division.
    logic signed [COORD_W-1:0]          pos [LANES];
    logic [DIAM_W-1:0]                  den_eff;
    logic [LANES-1:0][SCALE_NUM_W-1:0]  a_num_next;
    logic [LANES-1:0]                   a_neg_next;
    logic                               a_valid_reg;
    logic [LANES-1:0][SCALE_NUM_W-1:0]  a_num_reg;
    logic [LANES-1:0]                   a_neg_reg;
    logic [DIAM_W-1:0]                  a_den_reg;
    logic [LANES-1:0][DIAM_W-1:0]       a_den_vec;

    assign pos[0] = new_x;
    assign pos[1] = new_y;
    assign pos[2] = old_x;
    assign pos[3] = old_y;

    always_comb
    begin
        logic [COORD_W-1:0] mag;
        den_eff = (diameter_reg == '0) ? DIAM_W'(1) : diameter_reg;
        for (int l = 0; l < LANES; l++)
        begin
            a_neg_next[l] = pos[l][COORD_W-1];
            mag = a_neg_next[l] ? (COORD_W'(0) - pos[l]) : pos[l];
            a_num_next[l] = (SCALE_NUM_W'(mag) << SCALE_SHIFT)
                          + SCALE_NUM_W'(den_eff >> 1);
        end
    end

    assign hold_a = a_valid_reg && hold_scale;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (!hold_a)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold_a)
        begin
            a_num_reg <= a_num_next;
            a_neg_reg <= a_neg_next;
            a_den_reg <= den_eff;
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_den
        assign a_den_vec[l] = a_den_reg;
    end

    logic                               sc_valid;
    logic [LANES-1:0][SCALE_NUM_W-1:0]  sc_quo;
    logic [LANES-1:0]                   sc_neg;

    tra_udiv #(
        .LANES  (LANES),
        .NUM_W  (SCALE_NUM_W),
        .DEN_W  (DIAM_W),
        .Q_W    (SCALE_NUM_W),
        .SIDE_W (LANES)
    ) u_scale_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid_reg),
        .num       (a_num_reg),
        .den       (a_den_vec),
        .side      (a_neg_reg),
        .hold_in   (hold_m),
        .hold_out  (hold_scale),
        .out_valid (sc_valid),
        .quo       (sc_quo),
        .out_side  (sc_neg)
    );

    // Stage M: squares of the scaled coordinates.
    logic                          m_valid_reg;
    logic [LANES-1:0][SQ_W-1:0]    m_sq_reg;
    logic [LANES-1:0][MAG_W-1:0]   m_mag_reg;
    logic [LANES-1:0]              m_neg_reg;

    assign hold_m = m_valid_reg && hold_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (!hold_m)
        begin
            m_valid_reg <= sc_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold_m)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                m_mag_reg[l] <= sc_quo[l][MAG_W-1:0];
                m_sq_reg[l]  <= sc_quo[l][MAG_W-1:0] * sc_quo[l][MAG_W-1:0];
            end
            m_neg_reg <= sc_neg;
        end
    end

    // Stage S: squared radius of each point.
    logic                          s_valid_reg;
    logic [POINTS-1:0][SQ_W-1:0]   s_r2_reg;
    logic [LANES-1:0][MAG_W-1:0]   s_mag_reg;
    logic [LANES-1:0]              s_neg_reg;

    assign hold_s = s_valid_reg && hold_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (!hold_s)
        begin
            s_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold_s)
        begin
            for (int p = 0; p < POINTS; p++)
            begin
                s_r2_reg[p] <= m_sq_reg[2*p] + m_sq_reg[2*p+1];
            end
            s_mag_reg <= m_mag_reg;
            s_neg_reg <= m_neg_reg;
        end
    end

    // Stage V: on the ball the root gives z, off the ball it gives the length.
    logic                          v_valid_reg;
    logic [POINTS-1:0][SQ_W-1:0]   v_val_reg;
    sqrt_side_t                    v_side_reg;

    assign hold_v = v_valid_reg && hold_sqrt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_valid_reg <= 1'b0;
        end
        else if (!hold_v)
        begin
            v_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold_v)
        begin
            for (int p = 0; p < POINTS; p++)
            begin
                v_side_reg.on_ball[p] <= (s_r2_reg[p] <= ONE_Q32);
                v_val_reg[p] <= (s_r2_reg[p] <= ONE_Q32) ? (ONE_Q32 - s_r2_reg[p])
                                                        : s_r2_reg[p];
            end
            v_side_reg.mag <= s_mag_reg;
            v_side_reg.neg <= s_neg_reg;
        end
    end

    logic                          q_valid;
    logic [POINTS-1:0][ROOT_W-1:0] q_root;
    sqrt_side_t                    q_side;

    tra_sqrt #(
        .LANES  (POINTS),
        .V_W    (SQ_W),
        .SIDE_W ($bits(sqrt_side_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_valid_reg),
        .val       (v_val_reg),
        .side      (v_side_reg),
        .hold_in   (hold_n),
        .hold_out  (hold_sqrt),
        .out_valid (q_valid),
        .root      (q_root),
        .out_side  (q_side)
    );

    // Stage N: numerators for pulling an outside point onto the rim.
    logic                               n_valid_reg;
    logic [LANES-1:0][NORM_NUM_W-1:0]   n_num_reg;
    logic [LANES-1:0][ROOT_W-1:0]       n_den_reg;
    norm_side_t                         n_side_reg;

    assign hold_n = n_valid_reg && hold_norm;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_valid_reg <= 1'b0;
        end
        else if (!hold_n)
        begin
            n_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold_n)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                n_num_reg[l] <= {q_side.mag[l], {FRAC_W{1'b0}}}
                              + NORM_NUM_W'(q_root[l/2] >> 1);
                n_den_reg[l] <= q_root[l/2];
                n_side_reg.mag_in[l] <= q_side.mag[l][UNIT_W-1:0];
            end
            for (int p = 0; p < POINTS; p++)
            begin
                n_side_reg.z[p] <= q_root[p][UNIT_W-1:0];
            end
            n_side_reg.neg     <= q_side.neg;
            n_side_reg.on_ball <= q_side.on_ball;
        end
    end

    logic                             nd_valid;
    logic [LANES-1:0][NORM_Q_W-1:0]   nd_quo;
    norm_side_t                       nd_side;

    tra_udiv #(
        .LANES  (LANES),
        .NUM_W  (NORM_NUM_W),
        .DEN_W  (ROOT_W),
        .Q_W    (NORM_Q_W),
        .SIDE_W ($bits(norm_side_t))
    ) u_norm_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (n_valid_reg),
        .num       (n_num_reg),
        .den       (n_den_reg),
        .side      (n_side_reg),
        .hold_in   (hold_f),
        .hold_out  (hold_norm),
        .out_valid (nd_valid),
        .quo       (nd_quo),
        .out_side  (nd_side)
    );

    // Stage F: signed unit vectors of both points.
    logic   f_valid_reg;
    axis_t  f_vec_reg [LANES];
    axis_t  f_z_reg   [POINTS];
    axis_t  f_vec_next [LANES];
    axis_t  f_z_next   [POINTS];

    always_comb
    begin
        logic [AXIS_W-1:0] unit;
        for (int l = 0; l < LANES; l++)
        begin
            if (nd_side.on_ball[l/2])
            begin
                unit = AXIS_W'(nd_side.mag_in[l]);
            end
            else
            begin
                unit = (nd_quo[l] > ONE_Q16) ? ONE_Q16 : nd_quo[l];
            end
            f_vec_next[l] = nd_side.neg[l] ? axis_t'(AXIS_W'(0) - unit) : axis_t'(unit);
        end
        for (int p = 0; p < POINTS; p++)
        begin
            f_z_next[p] = nd_side.on_ball[p] ? axis_t'(AXIS_W'(nd_side.z[p])) : axis_t'(0);
        end
    end

    assign hold_f = f_valid_reg && hold_p;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (!hold_f)
        begin
            f_valid_reg <= nd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold_f)
        begin
            f_vec_reg <= f_vec_next;
            f_z_reg   <= f_z_next;
        end
    end

    // Stage P: the six products of the cross product.
    logic                       p_valid_reg;
    logic signed [PROD_W-1:0]   p_prod_reg [6];

    assign hold_p = p_valid_reg && hold_d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (!hold_p)
        begin
            p_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold_p)
        begin
            p_prod_reg[0] <= f_vec_reg[3] * f_z_reg[0];
            p_prod_reg[1] <= f_vec_reg[1] * f_z_reg[1];
            p_prod_reg[2] <= f_z_reg[1] * f_vec_reg[0];
            p_prod_reg[3] <= f_z_reg[0] * f_vec_reg[2];
            p_prod_reg[4] <= f_vec_reg[2] * f_vec_reg[1];
            p_prod_reg[5] <= f_vec_reg[0] * f_vec_reg[3];
        end
    end

    // Stage D: differences.
    logic                       d_valid_reg;
    logic signed [DIFF_W-1:0]   d_diff_reg [3];

    assign hold_d = d_valid_reg && hold_o;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (!hold_d)
        begin
            d_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold_d)
        begin
            for (int c = 0; c < 3; c++)
            begin
                d_diff_reg[c] <= p_prod_reg[2*c] - p_prod_reg[2*c+1];
            end
        end
    end

    // Stage O: round half away from zero to Q1.16, saturate, output register.
    logic   o_valid_reg;
    axis_t  o_axis_reg  [3];
    axis_t  o_axis_next [3];

    always_comb
    begin
        logic [DIFF_W-1:0] mag;
        logic [DIFF_W-1:0] rq;
        logic [AXIS_W-1:0] val;
        for (int c = 0; c < 3; c++)
        begin
            mag = d_diff_reg[c][DIFF_W-1] ? (DIFF_W'(0) - DIFF_W'(d_diff_reg[c]))
                                          : DIFF_W'(d_diff_reg[c]);
            rq  = (mag + HALF_Q16) >> FRAC_W;
            val = (rq > DIFF_W'(ONE_Q16)) ? ONE_Q16 : rq[AXIS_W-1:0];
            o_axis_next[c] = d_diff_reg[c][DIFF_W-1] ? axis_t'(AXIS_W'(0) - val)
                                                     : axis_t'(val);
        end
    end

    assign hold_o = o_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (!hold_o)
        begin
            o_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold_o)
        begin
            o_axis_reg <= o_axis_next;
        end
    end

    assign in_stall  = hold_a;
    assign out_valid = o_valid_reg;
    assign axis_x    = o_axis_reg[0];
    assign axis_y    = o_axis_reg[1];
    assign axis_z    = o_axis_reg[2];

endmodule

// ===== rtl/tra_checker.sv =====
// Port-level checker for the trackball rotation axis block and its bind statement.
module tra_checker
    import tra_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic signed [COORD_W-1:0]  new_x,
    input logic signed [COORD_W-1:0]  new_y,
    input logic signed [COORD_W-1:0]  old_x,
    input logic signed [COORD_W-1:0]  old_y,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic signed [AXIS_W-1:0]   axis_x,
    input logic signed [AXIS_W-1:0]   axis_y,
    input logic signed [AXIS_W-1:0]   axis_z
);

    // The input can only be held back when a finished item waits at a stalled output.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled output item");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_stall) |=> (in_valid && $stable(new_x) && $stable(new_y)
                                    && $stable(old_x) && $stable(old_y)))
        else $error("stalled input item changed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(axis_x)
                                      && $stable(axis_y) && $stable(axis_z)))
        else $error("stalled output item changed");

    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (axis_x <= AXIS_MAX && axis_x >= AXIS_MIN
                       && axis_y <= AXIS_MAX && axis_y >= AXIS_MIN
                       && axis_z <= AXIS_MAX && axis_z >= AXIS_MIN))
        else $error("axis component outside the unit range");

endmodule

bind trackball_rotation_axis tra_checker u_tra_checker (.*);
